[design/ffem_pkg.sv]
// shared types, constants and codes of the first-fit extent map allocator
// no dependencies
`timescale 1ns / 1ps

package ffem_pkg;

	localparam int MAP_ENTRIES = 32;
	localparam int BLOCK_BITS  = 16;
	localparam int IDX_BITS    = $clog2(MAP_ENTRIES);
	localparam int CNT_BITS    = $clog2(MAP_ENTRIES + 1);
	localparam int CFG_DATA_BITS = 16;

	typedef logic [BLOCK_BITS-1:0] blk_t;
	typedef logic [BLOCK_BITS:0]   blk_sum_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [0:0]            cfg_idx_t;

	localparam cfg_idx_t CFG_POOL_START  = 1'b0;
	localparam cfg_idx_t CFG_POOL_LENGTH = 1'b1;

	localparam cnt_t MAP_FULL = cnt_t'(MAP_ENTRIES);

	typedef struct packed {
		blk_t start;
		blk_t length;
	} entry_t;

	// one write and one read port per cycle
	typedef struct packed {
		logic   wr_en;
		idx_t   wr_idx;
		entry_t wr_data;
		idx_t   rd_idx;
	} mem_req_t;

	typedef enum logic [1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_INIT  = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_FULL    = 2'd2,
		ST_ZERO    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CK,
		S_FREE_DEC,
		S_SHL_RD,
		S_SHL_WR,
		S_SHR_RD,
		S_SHR_WR,
		S_DONE
	} state_t;

endpackage

[design/ffem_if.sv]
// request and response channels of the extent map allocator
// depends on ffem_pkg
`timescale 1ns / 1ps

interface ffem_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	ffem_pkg::blk_t    block_count;
	ffem_pkg::blk_t    block_address;

	modport source (output valid, func, block_count, block_address, input ready);
	modport sink (input valid, func, block_count, block_address, output ready);
endinterface

interface ffem_rsp_if;
	logic              valid;
	logic              ready;
	ffem_pkg::blk_t    granted_address;
	logic [1:0]        status;

	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

[design/ffem_store.sv]
// extent map storage: one synchronous memory of (start, length) entries
// depends on ffem_pkg
`timescale 1ns / 1ps

module ffem_store (
	input  logic               clk,
	input  ffem_pkg::mem_req_t req,
	output ffem_pkg::entry_t   rdata
);

	ffem_pkg::entry_t mem [ffem_pkg::MAP_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[req.rd_idx];
	end

endmodule

[design/ffem_ctrl.sv]
// sequencer: scan, trim, insert, join and shift over the extent memory
// depends on ffem_pkg, ffem_if
`timescale 1ns / 1ps

module ffem_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  ffem_pkg::blk_t     pool_start,
	input  ffem_pkg::blk_t     pool_length,
	ffem_req_if.sink           req,
	ffem_rsp_if.source         rsp,
	output ffem_pkg::mem_req_t mem_req,
	input  ffem_pkg::entry_t   rdata
);

	ffem_pkg::state_t  state_q, state_d;
	ffem_pkg::func_t   op_q, op_d;
	ffem_pkg::blk_t    size_q, size_d;
	ffem_pkg::blk_t    blk_q, blk_d;
	ffem_pkg::cnt_t    count_q, count_d;
	ffem_pkg::cnt_t    p_q, p_d;
	ffem_pkg::cnt_t    j_q, j_d;
	ffem_pkg::entry_t  prev_q, prev_d;
	ffem_pkg::entry_t  cur_q, cur_d;
	ffem_pkg::blk_t    gnt_q, gnt_d;
	ffem_pkg::status_t st_q, st_d;
	logic              rsp_valid_q, rsp_valid_d;
	ffem_pkg::blk_t    rsp_gnt_q, rsp_gnt_d;
	ffem_pkg::status_t rsp_st_q, rsp_st_d;

	// join arithmetic, ends compared without wrap
	ffem_pkg::blk_sum_t prev_end, left_len, left_end, merged_len, right_end, right_len;
	logic               prev_ok, cur_ok, join_left, join_both, join_right;

	always_comb begin
		prev_end   = ffem_pkg::blk_sum_t'(prev_q.start) + ffem_pkg::blk_sum_t'(prev_q.length);
		left_len   = ffem_pkg::blk_sum_t'(prev_q.length) + ffem_pkg::blk_sum_t'(size_q);
		left_end   = ffem_pkg::blk_sum_t'(prev_q.start) + ffem_pkg::blk_sum_t'(left_len[ffem_pkg::BLOCK_BITS-1:0]);
		merged_len = ffem_pkg::blk_sum_t'(left_len[ffem_pkg::BLOCK_BITS-1:0])
			+ ffem_pkg::blk_sum_t'(cur_q.length);
		right_end  = ffem_pkg::blk_sum_t'(blk_q) + ffem_pkg::blk_sum_t'(size_q);
		right_len  = ffem_pkg::blk_sum_t'(cur_q.length) + ffem_pkg::blk_sum_t'(size_q);
		prev_ok    = (p_q != '0);
		cur_ok     = (p_q < count_q);
		join_left  = prev_ok && (prev_end == ffem_pkg::blk_sum_t'(blk_q))
			&& !left_len[ffem_pkg::BLOCK_BITS];
		join_both  = join_left && cur_ok && (left_end == ffem_pkg::blk_sum_t'(cur_q.start))
			&& !merged_len[ffem_pkg::BLOCK_BITS];
		join_right = cur_ok && (right_end == ffem_pkg::blk_sum_t'(cur_q.start))
			&& !right_len[ffem_pkg::BLOCK_BITS];
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		size_d      = size_q;
		blk_d       = blk_q;
		count_d     = count_q;
		p_d         = p_q;
		j_d         = j_q;
		prev_d      = prev_q;
		cur_d       = cur_q;
		gnt_d       = gnt_q;
		st_d        = st_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		rsp_gnt_d   = rsp_gnt_q;
		rsp_st_d    = rsp_st_q;
		mem_req     = '0;
		mem_req.rd_idx = p_q[ffem_pkg::IDX_BITS-1:0];
		req.ready   = (state_q == ffem_pkg::S_IDLE);

		unique case (state_q)
			ffem_pkg::S_IDLE: begin
				if (req.valid) begin
					op_d   = ffem_pkg::func_t'(req.func);
					size_d = req.block_count;
					blk_d  = req.block_address;
					gnt_d  = '0;
					st_d   = ffem_pkg::ST_OK;
					p_d    = '0;
					unique case (ffem_pkg::func_t'(req.func))
						ffem_pkg::FN_ALLOC, ffem_pkg::FN_FREE: begin
							if (req.block_count == '0) begin
								st_d    = ffem_pkg::ST_ZERO;
								state_d = ffem_pkg::S_DONE;
							end else begin
								state_d = ffem_pkg::S_SCAN_RD;
							end
						end
						ffem_pkg::FN_INIT: begin
							// entries above the count are never read, so one write suffices
							mem_req.wr_en   = 1'b1;
							mem_req.wr_idx  = '0;
							mem_req.wr_data = '{start: pool_start, length: pool_length};
							count_d = (pool_length != '0) ? ffem_pkg::cnt_t'(1) : '0;
							state_d = ffem_pkg::S_DONE;
						end
						ffem_pkg::FN_NONE: begin
							state_d = ffem_pkg::S_DONE;
						end
					endcase
				end
			end

			ffem_pkg::S_SCAN_RD: begin
				if (p_q >= count_q) begin
					if (op_q == ffem_pkg::FN_ALLOC) begin
						st_d    = ffem_pkg::ST_NOSPACE;
						state_d = ffem_pkg::S_DONE;
					end else begin
						state_d = ffem_pkg::S_FREE_DEC;
					end
				end else begin
					mem_req.rd_idx = p_q[ffem_pkg::IDX_BITS-1:0];
					state_d = ffem_pkg::S_SCAN_CK;
				end
			end

			ffem_pkg::S_SCAN_CK: begin
				if (op_q == ffem_pkg::FN_ALLOC) begin
					priority if (rdata.length == size_q) begin
						// exact fit: remove the entry
						gnt_d   = rdata.start;
						j_d     = p_q;
						state_d = ffem_pkg::S_SHL_RD;
					end else if (rdata.length > size_q) begin
						// trim from the front
						gnt_d   = rdata.start;
						mem_req.wr_en   = 1'b1;
						mem_req.wr_idx  = p_q[ffem_pkg::IDX_BITS-1:0];
						mem_req.wr_data = '{start: rdata.start + size_q,
							length: rdata.length - size_q};
						state_d = ffem_pkg::S_DONE;
					end else begin
						p_d     = p_q + ffem_pkg::cnt_t'(1);
						state_d = ffem_pkg::S_SCAN_RD;
					end
				end else begin
					if (rdata.start < blk_q) begin
						prev_d  = rdata;
						p_d     = p_q + ffem_pkg::cnt_t'(1);
						state_d = ffem_pkg::S_SCAN_RD;
					end else begin
						cur_d   = rdata;
						state_d = ffem_pkg::S_FREE_DEC;
					end
				end
			end

			ffem_pkg::S_FREE_DEC: begin
				priority if (join_left) begin
					mem_req.wr_en  = 1'b1;
					mem_req.wr_idx = p_q[ffem_pkg::IDX_BITS-1:0] - ffem_pkg::idx_t'(1);
					if (join_both) begin
						// lower, freed and upper extents become one
						mem_req.wr_data = '{start: prev_q.start,
							length: merged_len[ffem_pkg::BLOCK_BITS-1:0]};
						j_d     = p_q;
						state_d = ffem_pkg::S_SHL_RD;
					end else begin
						mem_req.wr_data = '{start: prev_q.start,
							length: left_len[ffem_pkg::BLOCK_BITS-1:0]};
						state_d = ffem_pkg::S_DONE;
					end
				end else if (join_right) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_idx  = p_q[ffem_pkg::IDX_BITS-1:0];
					mem_req.wr_data = '{start: blk_q,
						length: right_len[ffem_pkg::BLOCK_BITS-1:0]};
					state_d = ffem_pkg::S_DONE;
				end else if (count_q >= ffem_pkg::MAP_FULL) begin
					st_d    = ffem_pkg::ST_FULL;
					state_d = ffem_pkg::S_DONE;
				end else begin
					j_d     = count_q;
					state_d = ffem_pkg::S_SHR_RD;
				end
			end

			// move entries down one place from j+1 to the end
			ffem_pkg::S_SHL_RD: begin
				if ((j_q + ffem_pkg::cnt_t'(1)) >= count_q) begin
					count_d = count_q - ffem_pkg::cnt_t'(1);
					state_d = ffem_pkg::S_DONE;
				end else begin
					mem_req.rd_idx = j_q[ffem_pkg::IDX_BITS-1:0] + ffem_pkg::idx_t'(1);
					state_d = ffem_pkg::S_SHL_WR;
				end
			end

			ffem_pkg::S_SHL_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_idx  = j_q[ffem_pkg::IDX_BITS-1:0];
				mem_req.wr_data = rdata;
				j_d     = j_q + ffem_pkg::cnt_t'(1);
				state_d = ffem_pkg::S_SHL_RD;
			end

			// open a hole at p by moving entries up from the end
			ffem_pkg::S_SHR_RD: begin
				if (j_q == p_q) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_idx  = p_q[ffem_pkg::IDX_BITS-1:0];
					mem_req.wr_data = '{start: blk_q, length: size_q};
					count_d = count_q + ffem_pkg::cnt_t'(1);
					state_d = ffem_pkg::S_DONE;
				end else begin
					mem_req.rd_idx = j_q[ffem_pkg::IDX_BITS-1:0] - ffem_pkg::idx_t'(1);
					state_d = ffem_pkg::S_SHR_WR;
				end
			end

			ffem_pkg::S_SHR_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_idx  = j_q[ffem_pkg::IDX_BITS-1:0];
				mem_req.wr_data = rdata;
				j_d     = j_q - ffem_pkg::cnt_t'(1);
				state_d = ffem_pkg::S_SHR_RD;
			end

			ffem_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d = 1'b1;
					rsp_gnt_d   = (op_q == ffem_pkg::FN_ALLOC) ? gnt_q : '0;
					rsp_st_d    = st_q;
					state_d     = ffem_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = ffem_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffem_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		size_q    <= size_d;
		blk_q     <= blk_d;
		p_q       <= p_d;
		j_q       <= j_d;
		prev_q    <= prev_d;
		cur_q     <= cur_d;
		gnt_q     <= gnt_d;
		st_q      <= st_d;
		rsp_gnt_q <= rsp_gnt_d;
		rsp_st_q  <= rsp_st_d;
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.granted_address = rsp_gnt_q;
	assign rsp.status          = rsp_st_q;

endmodule

[design/first_fit_extent_map_allocator.sv]
// top level of the first-fit extent map allocator: pool registers, sequencer, map memory
// depends on ffem_pkg, ffem_if, ffem_store, ffem_ctrl
`timescale 1ns / 1ps

// usage
// - req channel carries one item: func (allocate, free, init, no-op), block_count and
//   block_address; rsp returns one item per request: granted_address and status
// - cfg_we / cfg_index / cfg_data write pool_start (index 0) and pool_length
//   (index 1), which only init reads; write them while the block is idle
// - sequence: zero-size requests, init and the no-op code go straight to the
//   result state; allocate takes a read and a check state per entry scanned,
//   plus a read and a write state per entry moved down on an exact fit; free
//   does the same per entry scanned, plus a read and a write state per entry
//   moved up on an insert or down on a double join, since the map memory has a
//   single read and write port and a registered read
// - one item in work at a time; the next item is taken as soon as the
//   previous result sits in the output register, even if rsp is stalled
// - a stalled rsp holds its item; a result that finishes behind it waits
// - reset empties the map (entry count zero) and clears the pool registers;
//   no clearing pass is needed because entries above the count are never read
module first_fit_extent_map_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  ffem_pkg::cfg_idx_t              cfg_index,
	input  logic [ffem_pkg::CFG_DATA_BITS-1:0] cfg_data,
	ffem_req_if.sink                        req,
	ffem_rsp_if.source                      rsp
);

	ffem_pkg::blk_t     pool_start_q;
	ffem_pkg::blk_t     pool_length_q;
	ffem_pkg::mem_req_t mem_req;
	ffem_pkg::entry_t   mem_rdata;

	// pool registers for init
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_start_q  <= '0;
			pool_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffem_pkg::CFG_POOL_START:  pool_start_q  <= ffem_pkg::blk_t'(cfg_data);
				ffem_pkg::CFG_POOL_LENGTH: pool_length_q <= ffem_pkg::blk_t'(cfg_data);
			endcase
		end
	end

	// sequencer owns the handshakes and all read-modify-write steps
	ffem_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pool_start  (pool_start_q),
		.pool_length (pool_length_q),
		.req         (req),
		.rsp         (rsp),
		.mem_req     (mem_req),
		.rdata       (mem_rdata)
	);

	// sorted extent list; a step never reads the entry written in the same cycle
	ffem_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

[dv/tb.sv]
// self-checking testbench of the first-fit extent map allocator
// depends on ffem_pkg, ffem_if and first_fit_extent_map_allocator
`timescale 1ns / 1ps

module tb;
	import ffem_pkg::*;

	// largest length that one extent may hold
	localparam int BLK_MAX = (1 << BLOCK_BITS) - 1;
	// total items queued before the stimulus stops, and where idling stops
	localparam int RUN_ITEMS = 1120;
	localparam int QUIET_FROM = RUN_ITEMS - 180;
	// watchdog limit on quiet time, well above the slowest item plus gaps and stalls
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		func_t fn;
		blk_t  count;
		blk_t  addr;
	} op_item_t;

	typedef struct packed {
		blk_t    grant;
		status_t st;
	} answer_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	cfg_idx_t                 cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	ffem_req_if req_bus ();
	ffem_rsp_if rsp_bus ();

	first_fit_extent_map_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// shadow copy of the free-extent map and of the pool registers
	blk_t map_start [MAP_ENTRIES];
	blk_t map_len   [MAP_ENTRIES];
	int   map_used;
	int   peak_used;
	blk_t pool_base;
	blk_t pool_size;

	// items waiting for the driver, answers waiting for the monitor
	op_item_t pending_ops[$];
	answer_t  pending_answers[$];
	op_item_t cur_op;
	int       free_order[$];

	bit idle_on;
	int req_gap;
	int rsp_stall;
	int quiet_cycles;
	int items_queued;
	int items_done;
	int pool_loads;
	int errors;
	int st_seen [4];

	// ---------------------------------------------------------------
	// map behaviour
	// ---------------------------------------------------------------

	// remove one entry, close the gap and clear the top slot
	function automatic void drop_extent(input int at);
		int j;
		for (j = at; j + 1 < map_used; j++) begin
			map_start[j] = map_start[j + 1];
			map_len[j]   = map_len[j + 1];
		end
		map_used--;
		map_start[map_used] = '0;
		map_len[map_used]   = '0;
	endfunction

	// first fit: exact fit removes the entry, larger extents trimmed at the front
	function automatic status_t map_alloc(input blk_t size, output blk_t grant);
		int i;
		grant = '0;
		if (size == 0)
			return ST_ZERO;
		for (i = 0; i < map_used; i++) begin
			if (map_len[i] == size) begin
				grant = map_start[i];
				drop_extent(i);
				return ST_OK;
			end
			if (map_len[i] > size) begin
				grant = map_start[i];
				map_len[i]   = map_len[i] - size;
				// new start wraps at the block width
				map_start[i] = map_start[i] + size;
				return ST_OK;
			end
		end
		return ST_NOSPACE;
	endfunction

	// insert in address order, joining neighbours whose ends touch without wrap
	function automatic status_t map_free(input blk_t size, input blk_t blk);
		int p;
		int q;
		int j;
		int lo_end;
		int hi_end;
		int joined;
		if (size == 0)
			return ST_ZERO;
		p = 0;
		while (p < map_used && map_start[p] < blk)
			p++;
		if (p > 0) begin
			q = p - 1;
			lo_end = map_start[q];
			lo_end = lo_end + map_len[q];
			joined = map_len[q];
			joined = joined + size;
			if (lo_end == blk && joined <= BLK_MAX) begin
				map_len[q] = joined;
				lo_end = map_start[q];
				lo_end = lo_end + map_len[q];
				joined = map_len[q];
				if (p < map_used)
					joined = joined + map_len[p];
				// upper neighbour may now touch as well
				if (p < map_used && lo_end == map_start[p] && joined <= BLK_MAX) begin
					map_len[q] = joined;
					drop_extent(p);
				end
				return ST_OK;
			end
		end
		if (p < map_used) begin
			hi_end = blk;
			hi_end = hi_end + size;
			joined = map_len[p];
			joined = joined + size;
			if (hi_end == map_start[p] && joined <= BLK_MAX) begin
				map_start[p] = blk;
				map_len[p]   = joined;
				return ST_OK;
			end
		end
		if (map_used >= MAP_ENTRIES)
			return ST_FULL;
		for (j = map_used; j > p; j--) begin
			map_start[j] = map_start[j - 1];
			map_len[j]   = map_len[j - 1];
		end
		map_start[p] = blk;
		map_len[p]   = size;
		map_used++;
		return ST_OK;
	endfunction

	// work out the answer of one accepted item and queue it
	function automatic void apply_to_map(input op_item_t op);
		answer_t ans;
		int      j;
		ans.grant = '0;
		ans.st    = ST_OK;
		case (op.fn)
			FN_ALLOC: ans.st = map_alloc(op.count, ans.grant);
			FN_FREE:  ans.st = map_free(op.count, op.addr);
			FN_INIT: begin
				for (j = 0; j < MAP_ENTRIES; j++) begin
					map_start[j] = '0;
					map_len[j]   = '0;
				end
				map_used = 0;
				if (pool_size != 0) begin
					map_start[0] = pool_base;
					map_len[0]   = pool_size;
					map_used     = 1;
				end
			end
			default: ;
		endcase
		if (map_used > peak_used)
			peak_used = map_used;
		pending_answers.push_back(ans);
	endfunction

	// ---------------------------------------------------------------
	// clock, driver, monitor, watchdog
	// ---------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver: holds an item until taken, random gaps between items
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				apply_to_map(cur_op);
				items_done++;
			end
			// slot is free when nothing is offered or the offer was just taken
			if (!req_bus.valid || req_bus.ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_bus.valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					cur_op = pending_ops.pop_front();
					req_bus.valid         <= 1'b1;
					req_bus.func          <= cur_op.fn;
					req_bus.block_count   <= cur_op.count;
					req_bus.block_address <= cur_op.addr;
					if (idle_on && $urandom_range(0, 5) == 0)
						req_gap = $urandom_range(1, 9);
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: checks the oldest answer, stalls in random bursts
	always @(posedge clk) begin
		answer_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (pending_answers.size() == 0) begin
					$display("%0t: unexpected item, granted_address %h status %0d",
						$time, rsp_bus.granted_address, rsp_bus.status);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					st_seen[want.st]++;
					if (rsp_bus.granted_address !== want.grant) begin
						$display("%0t: granted_address expected %h actual %h",
							$time, want.grant, rsp_bus.granted_address);
						errors++;
					end
					if (rsp_bus.status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, rsp_bus.status);
						errors++;
					end
				end
			end
			if (rsp_stall == 0 && idle_on && $urandom_range(0, 7) == 0)
				rsp_stall = $urandom_range(1, 9);
			if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
			|| cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// wait at a falling edge until every item is taken and answered
	task automatic settle();
		@(negedge clk);
		while (pending_ops.size() != 0 || pending_answers.size() != 0 || req_bus.valid)
			@(negedge clk);
	endtask

	// write both pool registers, only ever called while the block is idle
	task automatic load_pool(input blk_t base, input blk_t size);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_POOL_START;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= CFG_POOL_LENGTH;
		cfg_data  <= size;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pool_base = base;
		pool_size = size;
		pool_loads++;
	endtask

	task automatic queue_op(input func_t fn, input blk_t count, input blk_t addr);
		op_item_t op;
		op.fn    = fn;
		op.count = count;
		op.addr  = addr;
		pending_ops.push_back(op);
		items_queued++;
	endtask

	// random permutation of 0 .. n-1
	task automatic shuffle_order(input int n);
		int i;
		int j;
		int t;
		free_order.delete();
		for (i = 0; i < n; i++)
			free_order.push_back(i);
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = free_order[i];
			free_order[i] = free_order[j];
			free_order[j] = t;
		end
	endtask

	// values biased towards the edges of the field
	function automatic blk_t pick_blk();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return blk_t'($urandom_range(1, 16));
			default: return blk_t'($urandom_range(0, BLK_MAX));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		int   n;
		int   k;
		int   sum;
		int   kind;
		blk_t base;
		blk_t len;
		blk_t sz;
		blk_t at;
		blk_t grant_at[$];
		blk_t grant_sz[$];

		// known values on every input from time zero
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_POOL_START;
		cfg_data              = '0;
		req_bus.valid         = 1'b0;
		req_bus.func          = FN_NONE;
		req_bus.block_count   = '0;
		req_bus.block_address = '0;
		rsp_bus.ready         = 1'b0;
		idle_on               = 1'b1;
		map_used              = 0;
		for (k = 0; k < MAP_ENTRIES; k++) begin
			map_start[k] = '0;
			map_len[k]   = '0;
		end
		pool_base = '0;
		pool_size = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty map: no space, zero-size requests, unused code, empty init,
		// then two inserts and a double join, and an exact fit
		load_pool('0, '0);
		queue_op(FN_ALLOC, 16'd1, '0);
		queue_op(FN_ALLOC, '0, '1);
		queue_op(FN_FREE, '0, '1);
		queue_op(FN_NONE, '1, '1);
		queue_op(FN_INIT, '0, '0);
		queue_op(FN_FREE, 16'd5, 16'h0100);
		queue_op(FN_FREE, 16'd5, 16'h010A);
		queue_op(FN_FREE, 16'd5, 16'h0105);
		queue_op(FN_ALLOC, 16'd15, '0);

		// pool running past the top: trimmed start wraps, join from above
		settle();
		load_pool(16'hFFF0, 16'h0020);
		queue_op(FN_INIT, '0, '0);
		queue_op(FN_ALLOC, 16'h0018, '0);
		queue_op(FN_FREE, 16'h0010, 16'hFFF0);
		queue_op(FN_FREE, 16'h0008, 16'h0000);
		queue_op(FN_ALLOC, '1, '0);

		// full-size pool: a join that would overflow the length stays apart
		settle();
		load_pool('0, '1);
		queue_op(FN_INIT, '0, '0);
		queue_op(FN_FREE, 16'h0010, 16'hFFFF);
		queue_op(FN_ALLOC, '1, '0);
		queue_op(FN_FREE, 16'd1, 16'hFFFE);
		queue_op(FN_ALLOC, 16'h0011, '0);

		// single block at the very top of the address space
		settle();
		load_pool('1, 16'd1);
		queue_op(FN_INIT, '0, '0);
		queue_op(FN_ALLOC, 16'd1, '0);
		queue_op(FN_FREE, 16'd1, '1);

		// random phases until enough items have gone in
		while (items_queued < RUN_ITEMS) begin
			settle();
			idle_on = (items_queued < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 9);
			grant_at.delete();
			grant_sz.delete();
			if (kind < 4) begin
				// churn: allocations that all fit, freed back in random order
				n = $urandom_range(4, 24);
				if ($urandom_range(0, 3) == 0)
					base = 16'hFF00 | blk_t'($urandom_range(0, 255));
				else
					base = blk_t'($urandom_range(0, BLK_MAX));
				if ($urandom_range(0, 4) == 0)
					len = '1;
				else
					len = blk_t'($urandom_range(n * 4, 20000));
				load_pool(base, len);
				queue_op(FN_INIT, pick_blk(), pick_blk());
				at = base;
				for (k = 0; k < n; k++) begin
					sz = blk_t'($urandom_range(1, len / n));
					queue_op(FN_ALLOC, sz, pick_blk());
					grant_at.push_back(at);
					grant_sz.push_back(sz);
					at = at + sz;
				end
				shuffle_order(n);
				for (k = 0; k < n; k++) begin
					if ($urandom_range(0, 5) == 0)
						queue_op(FN_ALLOC, blk_t'($urandom_range(1, 64)), pick_blk());
					if ($urandom_range(0, 9) == 0)
						queue_op(FN_FREE, '0, pick_blk());
					queue_op(FN_FREE, grant_sz[free_order[k]], grant_at[free_order[k]]);
				end
				queue_op(FN_ALLOC, len, pick_blk());
			end else if (kind < 7) begin
				// fragmentation: free every other piece, which can fill the map,
				// then the rest so that holes join on both sides
				n = $urandom_range(36, 70);
				sum = 0;
				for (k = 0; k < n; k++) begin
					grant_sz.push_back(blk_t'($urandom_range(1, 2)));
					sum += grant_sz[k];
				end
				if ($urandom_range(0, 3) != 0)
					sum += $urandom_range(1, 50);
				base = blk_t'($urandom_range(0, BLK_MAX));
				load_pool(base, blk_t'(sum));
				queue_op(FN_INIT, pick_blk(), pick_blk());
				at = base;
				for (k = 0; k < n; k++) begin
					queue_op(FN_ALLOC, grant_sz[k], pick_blk());
					grant_at.push_back(at);
					at = at + grant_sz[k];
				end
				if ($urandom_range(0, 1) == 0) begin
					for (k = 0; k < n; k += 2)
						queue_op(FN_FREE, grant_sz[k], grant_at[k]);
				end else begin
					for (k = (n - 1) & ~1; k >= 0; k -= 2)
						queue_op(FN_FREE, grant_sz[k], grant_at[k]);
				end
				shuffle_order(n / 2);
				for (k = 0; k < n / 2; k++)
					queue_op(FN_FREE, grant_sz[2 * free_order[k] + 1],
						grant_at[2 * free_order[k] + 1]);
			end else begin
				// noise on whatever map is left, sometimes from a fresh pool
				if ($urandom_range(0, 1) == 0) begin
					load_pool(pick_blk(), pick_blk());
					queue_op(FN_INIT, pick_blk(), pick_blk());
				end
				n = $urandom_range(10, 40);
				for (k = 0; k < n; k++) begin
					kind = $urandom_range(0, 3);
					if (kind == FN_INIT && $urandom_range(0, 2) != 0)
						kind = FN_FREE;
					queue_op(func_t'(kind), pick_blk(), blk_t'($urandom_range(0, BLK_MAX)));
				end
			end
		end

		// drain, then a hold-off to catch stray results
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d items over %0d pool settings, peak map use %0d of %0d",
			items_done, pool_loads, peak_used, MAP_ENTRIES);
		$display("answers: %0d ok, %0d out of space, %0d map full, %0d zero size",
			st_seen[ST_OK], st_seen[ST_NOSPACE], st_seen[ST_FULL], st_seen[ST_ZERO]);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
